// ===== rtl/fmq_pkg.sv =====
// ----------------------------------------------------------------------------
// fmq_pkg
// Shared sizes, codes, types and helpers for the fixed-latency memory queue.
// ----------------------------------------------------------------------------
package fmq_pkg;

  // Storage sizes. MEM_DEPTH is a power of two: addresses wrap on the low bits.
  localparam int MEM_DEPTH          = 1024;
  localparam int WORD_BITS          = 32;
  localparam int REQ_QUEUE_DEPTH    = 16;
  localparam int RESULT_QUEUE_DEPTH = 16;

  // Field widths on the ports
  localparam int CMD_BITS    = 2;
  localparam int ADDR_BITS   = 10;
  localparam int DATA_BITS   = 32;
  localparam int LAT_BITS    = 8;
  localparam int STATUS_BITS = 2;

  localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int REQ_AW = (REQ_QUEUE_DEPTH > 1) ? $clog2(REQ_QUEUE_DEPTH) : 1;
  localparam int REQ_CW = $clog2(REQ_QUEUE_DEPTH + 1);
  localparam int RES_AW = (RESULT_QUEUE_DEPTH > 1) ? $clog2(RESULT_QUEUE_DEPTH) : 1;
  localparam int RES_CW = $clog2(RESULT_QUEUE_DEPTH + 1);

  localparam logic [LAT_BITS-1:0] LATENCY_RESET = LAT_BITS'(1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_POP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NO_RESULT = 2'd2
  } status_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_RDWAIT
  } state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_BITS-1:0]  addr;
    logic [WORD_BITS-1:0]  value;
  } req_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    req_entry_t entry;
  } req_ctrl_t;

  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic [WORD_BITS-1:0] data;
  } res_ctrl_t;

  // Port data to stored word: keep the low WORD_BITS bits
  function automatic logic [WORD_BITS-1:0] to_word(logic [DATA_BITS-1:0] d);
    logic [63:0] ext;
    ext = 64'(d);
    return ext[WORD_BITS-1:0];
  endfunction

  // Stored word to port data: low DATA_BITS bits, zero filled
  function automatic logic [DATA_BITS-1:0] from_word(logic [WORD_BITS-1:0] w);
    logic [63:0] ext;
    ext = 64'(w);
    return ext[DATA_BITS-1:0];
  endfunction

  function automatic logic [MEM_AW-1:0] mem_index(logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS+MEM_AW-1:0] ext;
    ext = (ADDR_BITS + MEM_AW)'(a);
    return ext[MEM_AW-1:0];
  endfunction

endpackage

// ===== rtl/fmq_if.sv =====
// ----------------------------------------------------------------------------
// fmq_if
// Valid/ready channels of the memory queue: config write, item in, result out.
// ----------------------------------------------------------------------------
interface fmq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fmq_pkg::LAT_BITS-1:0]  latency_value;

  modport source (output valid, output latency_value, input ready);
  modport sink   (input valid, input latency_value, output ready);
endinterface

interface fmq_item_if;
  logic                                valid;
  logic                                ready;
  logic [fmq_pkg::CMD_BITS-1:0]        command;
  logic [fmq_pkg::ADDR_BITS-1:0]       address;
  logic signed [fmq_pkg::DATA_BITS-1:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink   (input valid, input command, input address, input write_data,
                  output ready);
endinterface

interface fmq_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fmq_pkg::DATA_BITS-1:0] read_data;
  logic                                 read_data_valid;
  logic [fmq_pkg::STATUS_BITS-1:0]      status;
  logic                                 busy_res;
  logic                                 result_available;

  modport source (output valid, output read_data, output read_data_valid,
                  output status, output busy_res, output result_available,
                  input ready);
  modport sink   (input valid, input read_data, input read_data_valid,
                  input status, input busy_res, input result_available,
                  output ready);
endinterface

// ===== rtl/fmq_word_ram.sv =====
// ----------------------------------------------------------------------------
// fmq_word_ram
// Simple dual-port word RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fmq_word_ram #(
  parameter  int DEPTH = 2,
  parameter  int WIDTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fmq_req_queue.sv =====
// ----------------------------------------------------------------------------
// fmq_req_queue
// Ring buffer of pending read/write requests; head entry shown at all times.
// ----------------------------------------------------------------------------
module fmq_req_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  fmq_pkg::req_ctrl_t           ctrl,
  output fmq_pkg::req_entry_t          head,
  output logic [fmq_pkg::REQ_CW-1:0]   count
);
  import fmq_pkg::*;

  req_entry_t        slots [REQ_QUEUE_DEPTH];
  logic [REQ_AW-1:0] rd_ptr;
  logic [REQ_AW-1:0] wr_ptr;
  logic              do_push;
  logic              do_pop;

  function automatic logic [REQ_AW-1:0] bump(logic [REQ_AW-1:0] p);
    return (p == REQ_AW'(REQ_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign do_push = ctrl.push && (count != REQ_CW'(REQ_QUEUE_DEPTH));
  assign do_pop  = ctrl.pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= ctrl.entry;
    end
  end

  assign head = slots[rd_ptr];

endmodule

// ===== rtl/fmq_res_queue.sv =====
// ----------------------------------------------------------------------------
// fmq_res_queue
// Ring buffer of completed read words, popped oldest first.
// ----------------------------------------------------------------------------
module fmq_res_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  fmq_pkg::res_ctrl_t              ctrl,
  output logic [fmq_pkg::WORD_BITS-1:0]   head,
  output logic [fmq_pkg::RES_CW-1:0]      count
);
  import fmq_pkg::*;

  logic [WORD_BITS-1:0] slots [RESULT_QUEUE_DEPTH];
  logic [RES_AW-1:0]    rd_ptr;
  logic [RES_AW-1:0]    wr_ptr;
  logic                 do_push;
  logic                 do_pop;

  function automatic logic [RES_AW-1:0] bump(logic [RES_AW-1:0] p);
    return (p == RES_AW'(RESULT_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign do_push = ctrl.push && (count != RES_CW'(RESULT_QUEUE_DEPTH));
  assign do_pop  = ctrl.pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entries hold no reset value; only written entries are ever popped
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= ctrl.data;
    end
  end

  assign head = slots[rd_ptr];

endmodule

// ===== rtl/fixed_latency_memory_queue.sv =====
// ----------------------------------------------------------------------------
// fixed_latency_memory_queue
// Word memory behind an in-order request queue with a per-request countdown.
// ----------------------------------------------------------------------------
// After reset the block sweeps the word RAM to zero, one word a cycle, through
// all MEM_DEPTH (1024) words; item.ready stays low during the sweep, config
// writes are taken at any time. Each item then returns one result. A tick that
// completes a read also passes through ST_RDWAIT, where the RAM's registered
// read word enters the result queue and item.ready stays low. The result sits
// in an output register, so the next item is taken while the previous result
// is still being handed off as long as the output register is empty or drains
// in the same cycle.
module fixed_latency_memory_queue (
  input  logic       clk,
  input  logic       rst,
  fmq_cfg_if.sink    cfg,
  fmq_item_if.sink   item,
  fmq_result_if.source result
);
  import fmq_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [MEM_AW-1:0]    clr_addr;
  logic                 clr_last;
  logic [LAT_BITS-1:0]  latency;
  logic [LAT_BITS-1:0]  countdown;

  req_ctrl_t            req_ctrl;
  req_entry_t           req_head;
  logic [REQ_CW-1:0]    req_count;
  res_ctrl_t            res_ctrl;
  logic [WORD_BITS-1:0] res_head;
  logic [RES_CW-1:0]    res_count;

  logic                 ram_we;
  logic [MEM_AW-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 out_valid;
  logic [DATA_BITS-1:0] out_data;
  logic                 out_dvalid;
  status_t              out_status;
  logic                 out_busy;
  logic                 out_avail;

  logic                 out_load;
  logic [DATA_BITS-1:0] load_data;
  logic                 load_dvalid;
  status_t              load_status;
  logic                 load_busy;
  logic                 load_avail;

  logic                 accept;
  cmd_t                 cmd;
  logic                 req_empty;
  logic                 req_full;
  logic                 res_empty;
  logic                 res_full;
  logic                 head_due;
  logic                 tick_live;
  logic                 tick_go;
  logic                 done_write;
  logic                 start_read;
  logic                 read_stall;

  fmq_word_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mem_index(req_head.addr)),
    .rdata (ram_rdata)
  );

  fmq_req_queue u_req_queue (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (req_ctrl),
    .head  (req_head),
    .count (req_count)
  );

  fmq_res_queue u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (res_ctrl),
    .head  (res_head),
    .count (res_count)
  );

  // --- handshake and decode ---
  assign cfg.ready  = 1'b1;
  assign item.ready = (state == ST_RUN) && (!out_valid || result.ready);
  assign accept     = item.valid && item.ready;
  assign cmd        = cmd_t'(item.command);

  assign req_empty = (req_count == '0);
  assign req_full  = (req_count == REQ_CW'(REQ_QUEUE_DEPTH));
  assign res_empty = (res_count == '0);
  assign res_full  = (res_count == RES_CW'(RESULT_QUEUE_DEPTH));
  // 0 and 1 both mean the head is due on this tick
  assign head_due  = (countdown <= LAT_BITS'(1));
  assign clr_last  = (clr_addr == MEM_AW'(MEM_DEPTH - 1));

  always_comb begin
    tick_live  = accept && (cmd == CMD_TICK) && !req_empty;
    tick_go    = tick_live && head_due;
    done_write = tick_go && (req_head.kind == KIND_WRITE);
    start_read = tick_go && (req_head.kind == KIND_READ) && !res_full;
    read_stall = tick_go && (req_head.kind == KIND_READ) && res_full;
  end

  // --- state machine ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_RUN;
      ST_RUN:    if (start_read) state_next = ST_RDWAIT;
      ST_RDWAIT: state_next = ST_RUN;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = mem_index(req_head.addr);
    ram_wdata      = req_head.value;
    ram_re         = 1'b0;
    req_ctrl.push  = 1'b0;
    req_ctrl.pop   = 1'b0;
    req_ctrl.entry = '{kind: KIND_READ, addr: item.address, value: '0};
    res_ctrl.push  = 1'b0;
    res_ctrl.pop   = 1'b0;
    res_ctrl.data  = ram_rdata;
    out_load       = 1'b0;
    load_data      = '0;
    load_dvalid    = 1'b0;
    load_status    = STAT_OK;
    load_busy      = !req_empty;
    load_avail     = !res_empty;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_RUN: begin
        if (accept) begin
          out_load = !start_read;
          unique case (cmd)
            CMD_TICK: begin
              if (done_write) begin
                ram_we       = 1'b1;
                req_ctrl.pop = 1'b1;
                load_busy    = (req_count != REQ_CW'(1));
              end else if (start_read) begin
                ram_re       = 1'b1;
                req_ctrl.pop = 1'b1;
              end
            end
            CMD_READ, CMD_WRITE: begin
              if (req_full) begin
                load_status = STAT_FULL;
              end else begin
                req_ctrl.push  = 1'b1;
                load_busy      = 1'b1;
                req_ctrl.entry = '{
                  kind:  (cmd == CMD_WRITE) ? KIND_WRITE : KIND_READ,
                  addr:  item.address,
                  value: (cmd == CMD_WRITE) ? to_word($unsigned(item.write_data))
                                            : '0
                };
              end
            end
            CMD_POP: begin
              if (res_empty) begin
                load_status = STAT_NO_RESULT;
              end else begin
                res_ctrl.pop = 1'b1;
                load_data    = from_word(res_head);
                load_dvalid  = 1'b1;
                load_avail   = (res_count != RES_CW'(1));
              end
            end
            default: load_status = STAT_OK;
          endcase
        end
      end
      ST_RDWAIT: begin
        // word from the RAM read issued last cycle goes into the result queue
        res_ctrl.push = 1'b1;
        out_load      = 1'b1;
        load_avail    = 1'b1;
      end
      default: ;
    endcase
  end

  // --- clear sweep, latency register, head countdown ---
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latency <= LATENCY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      latency <= cfg.latency_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown <= '0;
    end else if (req_ctrl.push && req_empty) begin
      countdown <= latency;
    end else if (tick_live && !head_due) begin
      countdown <= countdown - 1'b1;
    end else if (read_stall) begin
      countdown <= '0;
    end else if (tick_go) begin
      // next head (if any) starts its wait now
      countdown <= latency;
    end
  end

  // --- output register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data   <= load_data;
      out_dvalid <= load_dvalid;
      out_status <= load_status;
      out_busy   <= load_busy;
      out_avail  <= load_avail;
    end
  end

  assign result.valid            = out_valid;
  assign result.read_data        = $signed(out_data);
  assign result.read_data_valid  = out_dvalid;
  assign result.status           = out_status;
  assign result.busy_res         = out_busy;
  assign result.result_available = out_avail;

  // --- assertions ---
  a_rdwait_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDWAIT) |=> (state == ST_RUN) && out_valid)
    else $error("read completion did not load the output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!out_valid || result.ready))
    else $error("item taken while an undelivered result is held");

  a_rdwait_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDWAIT) |-> !res_full)
    else $error("read completion into a full result queue");

  a_req_bound: assert property (@(posedge clk) disable iff (rst)
    req_count <= REQ_CW'(REQ_QUEUE_DEPTH))
    else $error("request count beyond queue depth");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_CW'(RESULT_QUEUE_DEPTH))
    else $error("result count beyond queue depth");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-latency memory queue. A short scripted
// sequence covers edge cases, then random traffic runs in phases at different
// latencies. Every item is scored against its scripted result or an in-bench model of the queues.
// ----------------------------------------------------------------------------
module tb_top;
  import fmq_pkg::*;

  typedef struct packed {
    logic [DATA_BITS-1:0] rdata;
    logic                 rvalid;
    status_t              status;
    logic                 busy;
    logic                 avail;
  } mem_resp_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;
    logic                 typed;
    mem_resp_t            want;
  } script_row_t;

  typedef enum logic [1:0] {
    MIX_BALANCED,
    MIX_FILL,
    MIX_NO_POP,
    MIX_DRAIN
  } mix_t;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 128;
  localparam int SCRIPT_ROWS    = 24;
  localparam mem_resp_t BY_MODEL = '0;

  logic clk;
  logic rst;

  fmq_cfg_if    cfg_ch ();
  fmq_item_if   item_ch ();
  fmq_result_if res_ch ();

  fixed_latency_memory_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  // Model state
  logic [WORD_BITS-1:0] mem_words [MEM_DEPTH];
  req_entry_t           pending_reqs [$];
  logic [WORD_BITS-1:0] done_words [$];
  int unsigned          head_wait;
  logic [LAT_BITS-1:0]  lat_setting;

  mem_resp_t            resp_due [$];
  int                   errors;
  logic [ADDR_BITS-1:0] addr_base;

  // Scripted opening; rows with typed = 1 carry their own expected result
  script_row_t script [SCRIPT_ROWS] = '{
    '{CMD_POP,   10'h000, 32'h00000000, 1'b1, '{32'h0, 1'b0, STAT_NO_RESULT, 1'b0, 1'b0}},
    '{CMD_TICK,  10'h000, 32'h00000000, 1'b1, '{32'h0, 1'b0, STAT_OK, 1'b0, 1'b0}},
    '{CMD_WRITE, 10'h3FF, 32'h7FFFFFFF, 1'b1, '{32'h0, 1'b0, STAT_OK, 1'b1, 1'b0}},
    '{CMD_TICK,  10'h000, 32'h00000000, 1'b1, '{32'h0, 1'b0, STAT_OK, 1'b0, 1'b0}},
    '{CMD_READ,  10'h3FF, 32'h00000000, 1'b1, '{32'h0, 1'b0, STAT_OK, 1'b1, 1'b0}},
    '{CMD_TICK,  10'h000, 32'h00000000, 1'b1, '{32'h0, 1'b0, STAT_OK, 1'b0, 1'b1}},
    '{CMD_POP,   10'h000, 32'h00000000, 1'b1,
      '{32'h7FFFFFFF, 1'b1, STAT_OK, 1'b0, 1'b0}},
    '{CMD_WRITE, 10'h000, 32'h80000000, 1'b1, '{32'h0, 1'b0, STAT_OK, 1'b1, 1'b0}},
    '{CMD_READ,  10'h000, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_WRITE, 10'h2AA, 32'hFFFFFFFF, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h155, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h2AA, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_WRITE, 10'h155, 32'h55555555, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h155, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_WRITE, 10'h3FF, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h3FF, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h000, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_WRITE, 10'h001, 32'hDEADBEEF, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h001, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h200, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_WRITE, 10'h200, 32'h12345678, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h200, 32'h00000000, 1'b0, BY_MODEL},
    '{CMD_READ,  10'h3FF, 32'h00000000, 1'b0, BY_MODEL},
    // request queue holds 16 now: this one is dropped
    '{CMD_WRITE, 10'h100, 32'h00000001, 1'b1, '{32'h0, 1'b0, STAT_FULL, 1'b1, 1'b0}}
  };

  // Applies one item to the model state and returns its result
  function automatic mem_resp_t mem_queue_step(cmd_t cmd, logic [ADDR_BITS-1:0] addr,
                                               logic [DATA_BITS-1:0] data);
    mem_resp_t  r;
    req_entry_t req;
    bit         retire;
    r = '0;
    r.status = STAT_OK;
    retire = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (pending_reqs.size() != 0) begin
          if (head_wait > 1) begin
            head_wait--;
          end else begin
            head_wait = 0;
            req = pending_reqs[0];
            if (req.kind == KIND_WRITE) begin
              mem_words[req.addr] = req.value;
              retire = 1'b1;
            end else if (done_words.size() < RESULT_QUEUE_DEPTH) begin
              done_words.push_back(mem_words[req.addr]);
              retire = 1'b1;
            end
            // a read facing a full result queue stays at the head, count spent
            if (retire) begin
              void'(pending_reqs.pop_front());
              if (pending_reqs.size() != 0) head_wait = 32'(lat_setting);
            end
          end
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (pending_reqs.size() >= REQ_QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          req.kind  = (cmd == CMD_WRITE) ? KIND_WRITE : KIND_READ;
          req.addr  = addr;
          req.value = (cmd == CMD_WRITE) ? data : '0;
          if (pending_reqs.size() == 0) head_wait = 32'(lat_setting);
          pending_reqs.push_back(req);
        end
      end
      default: begin
        if (done_words.size() == 0) begin
          r.status = STAT_NO_RESULT;
        end else begin
          r.rdata  = done_words.pop_front();
          r.rvalid = 1'b1;
        end
      end
    endcase
    r.busy  = (pending_reqs.size() != 0);
    r.avail = (done_words.size() != 0);
    return r;
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic cmd_t pick_cmd(mix_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   return (r < 40) ? CMD_READ : (r < 75) ? CMD_WRITE :
                         (r < 90) ? CMD_TICK : CMD_POP;
      MIX_NO_POP: return (r < 55) ? CMD_TICK : (r < 90) ? CMD_READ : CMD_WRITE;
      MIX_DRAIN:  return (r < 40) ? CMD_TICK : CMD_POP;
      default:    return (r < 35) ? CMD_TICK : (r < 60) ? CMD_READ :
                         (r < 80) ? CMD_WRITE : CMD_POP;
    endcase
  endfunction

  // Mostly a small per-phase address pool so reads hit written words
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return addr_base ^ ADDR_BITS'($urandom_range(0, 15));
    return ADDR_BITS'($urandom_range(0, MEM_DEPTH - 1));
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_data();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      2:       return 32'h7FFFFFFF;
      default: return 32'h80000000;
    endcase
  endfunction

  task automatic send_item(input cmd_t cmd, input logic [ADDR_BITS-1:0] addr,
                           input logic [DATA_BITS-1:0] data, input logic typed,
                           input mem_resp_t want);
    mem_resp_t predicted;
    item_ch.valid      <= 1'b1;
    item_ch.command    <= cmd;
    item_ch.address    <= addr;
    item_ch.write_data <= data;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    predicted = mem_queue_step(cmd, addr, data);
    resp_due.push_back(typed ? want : predicted);
  endtask

  task automatic hold_off(input int cycles);
    item_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_latency(input logic [LAT_BITS-1:0] lat);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.latency_value <= lat;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    lat_setting = lat;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (resp_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // Result side: ready toggles with random stalls, sometimes long clear runs
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20))
        @(posedge clk);
      res_ch.ready <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
  end

  // Score every result transfer against the oldest expectation
  initial begin
    mem_resp_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (resp_due.size() == 0) begin
          $display("%0t: unexpected result: rd=%h v=%b st=%0d busy=%b avail=%b", $time,
                   res_ch.read_data, res_ch.read_data_valid, res_ch.status,
                   res_ch.busy_res, res_ch.result_available);
          errors++;
        end else begin
          want = resp_due.pop_front();
          if (res_ch.read_data !== want.rdata || res_ch.read_data_valid !== want.rvalid ||
              res_ch.status !== want.status || res_ch.busy_res !== want.busy ||
              res_ch.result_available !== want.avail) begin
            $display("%0t: mismatch exp rd=%h v=%b st=%0d busy=%b avail=%b", $time,
                     want.rdata, want.rvalid, want.status, want.busy, want.avail);
            $display("%0t:          got rd=%h v=%b st=%0d busy=%b avail=%b", $time,
                     res_ch.read_data, res_ch.read_data_valid, res_ch.status,
                     res_ch.busy_res, res_ch.result_available);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [LAT_BITS-1:0] lat_plan [PHASES];
    int                  items_left;
    int                  seg_len;
    mix_t                mix;
    bit                  quiet;
    errors = 0;
    foreach (mem_words[i]) mem_words[i] = '0;
    head_wait   = 0;
    lat_setting = LATENCY_RESET;
    lat_plan    = '{8'd1, 8'd2, 8'd0, 8'd5, 8'd4, 8'd3, 8'd7, 8'd255};
    lat_plan[4] = LAT_BITS'($urandom_range(0, 12));
    lat_plan[6] = LAT_BITS'($urandom_range(0, 12));

    rst                  <= 1'b1;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.latency_value <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.command      <= CMD_TICK;
    item_ch.address      <= '0;
    item_ch.write_data   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 0 behaves like 1, so the typed rows below hold either way
    write_latency(8'd0);
    foreach (script[i]) begin
      send_item(script[i].cmd, script[i].addr, script[i].data, script[i].typed,
                script[i].want);
      if ($urandom_range(0, 3) == 0) hold_off(pause_len());
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // every transfer so far is scored before the next latency is written
      wait_drained();
      write_latency(lat_plan[phase]);
      addr_base  = ADDR_BITS'($urandom_range(0, MEM_DEPTH - 1));
      items_left = PHASE_ITEMS;
      while (items_left > 0) begin
        seg_len = $urandom_range(16, 40);
        mix     = mix_t'($urandom_range(0, 3));
        quiet   = ($urandom_range(0, 3) == 0);
        while (seg_len > 0 && items_left > 0) begin
          send_item(pick_cmd(mix), pick_addr(), pick_data(), 1'b0, BY_MODEL);
          if (!quiet && $urandom_range(0, 9) < 3) hold_off(pause_len());
          seg_len--;
          items_left--;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fmq_pkg.sv
rtl/fmq_if.sv
rtl/fmq_word_ram.sv
rtl/fmq_req_queue.sv
rtl/fmq_res_queue.sv
rtl/fixed_latency_memory_queue.sv
bench/tb_top.sv
